### rtl/core/rotation_matrix_about_center_defines.svh
// Assertion macros for the rotation matrix block.
`ifndef ROTATION_MATRIX_ABOUT_CENTER_DEFINES_SVH
`define ROTATION_MATRIX_ABOUT_CENTER_DEFINES_SVH
`ifndef SYNTH
`define RMC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define RMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define RMC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RMC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/rmc_pkg.sv
// Package with types, constants and tables for the rotation matrix block.
`default_nettype none
package rmc_pkg;
	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_LEN = 24;
	localparam int RUN_STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
	localparam int XW = 56;
	localparam int ZW = 34;
	localparam int AW = 26;
	localparam int SW = 24;
	localparam int CW = 25;
	localparam int TW = 41;
	localparam int STEP_W = 5;
	localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
	localparam logic signed [AW:0] DEG_90 = (AW+1)'(90 * 65536);
	localparam logic signed [AW:0] DEG_180 = (AW+1)'(180 * 65536);
	localparam logic signed [AW:0] DEG_360 = (AW+1)'(360 * 65536);

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 flip;
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
	} cordic_t;

	function automatic logic signed [ZW-1:0] atan_q24(input logic [STEP_W-1:0] i);
		logic signed [ZW-1:0] v;
		unique case (i)
			5'd0: v = 34'sd754974720;  5'd1: v = 34'sd445687602;
			5'd2: v = 34'sd235489088;  5'd3: v = 34'sd119537938;
			5'd4: v = 34'sd60000934;   5'd5: v = 34'sd30029717;
			5'd6: v = 34'sd15018523;   5'd7: v = 34'sd7509720;
			5'd8: v = 34'sd3754917;    5'd9: v = 34'sd1877466;
			5'd10: v = 34'sd938734;    5'd11: v = 34'sd469367;
			5'd12: v = 34'sd234684;    5'd13: v = 34'sd117342;
			5'd14: v = 34'sd58671;     5'd15: v = 34'sd29335;
			5'd16: v = 34'sd14668;     5'd17: v = 34'sd7334;
			5'd18: v = 34'sd3667;      5'd19: v = 34'sd1833;
			5'd20: v = 34'sd917;       5'd21: v = 34'sd458;
			5'd22: v = 34'sd229;       5'd23: v = 34'sd115;
			default: v = '0;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

### rtl/core/rmc_if.sv
// Valid/ready channel interfaces for input and result transactions.
`default_nettype none
interface rmc_in_if;
	logic                       valid;
	logic                       ready;
	logic signed [rmc_pkg::AW-1:0] angle_deg;
	logic signed [rmc_pkg::SW-1:0] scale_factor;
	logic signed [rmc_pkg::CW-1:0] center_x;
	logic signed [rmc_pkg::CW-1:0] center_y;
	modport source (output valid, angle_deg, scale_factor, center_x, center_y, input ready);
	modport sink (input valid, angle_deg, scale_factor, center_x, center_y, output ready);
endinterface

interface rmc_out_if;
	logic                          valid;
	logic                          ready;
	logic signed [rmc_pkg::SW-1:0] coef_alpha;
	logic signed [rmc_pkg::SW-1:0] coef_beta;
	logic signed [rmc_pkg::SW-1:0] coef_neg_beta;
	logic signed [rmc_pkg::TW-1:0] shift_x;
	logic signed [rmc_pkg::TW-1:0] shift_y;
	modport source (output valid, coef_alpha, coef_beta, coef_neg_beta, shift_x, shift_y,
		input ready);
	modport sink (input valid, coef_alpha, coef_beta, coef_neg_beta, shift_x, shift_y,
		output ready);
endinterface
`default_nettype wire

### rtl/core/rmc_cell.sv
// One CORDIC micro-rotation cell with its pipeline register.
`default_nettype none
module rmc_cell (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic [rmc_pkg::STEP_W-1:0]   step,
	input  wire logic                         vld_in,
	input  wire rmc_pkg::cordic_t             d_in,
	output logic                              vld_out,
	output rmc_pkg::cordic_t                  d_out
);
	rmc_pkg::cordic_t nxt;
	always_comb begin
		nxt = d_in;
		if (!d_in.z[rmc_pkg::ZW-1]) begin
			nxt.x = d_in.x - (d_in.y >>> step);
			nxt.y = d_in.y + (d_in.x >>> step);
			nxt.z = d_in.z - rmc_pkg::atan_q24(step);
		end else begin
			nxt.x = d_in.x + (d_in.y >>> step);
			nxt.y = d_in.y - (d_in.x >>> step);
			nxt.z = d_in.z + rmc_pkg::atan_q24(step);
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_out <= 1'b0;
		else if (en) vld_out <= vld_in;
	end
	always_ff @(posedge clk) begin
		if (en) d_out <= nxt;
	end
endmodule
`default_nettype wire

### rtl/core/rotation_matrix_about_center.sv
// Throughput: one transaction per cycle; the whole pipe advances when the
// output register is empty or being drained, so a stall holds every stage.
// Stages: angle reduction, gain multiply, one cell per CORDIC step,
// rounding, one product stage, sum and saturation.
// Reset: arst_n clears all valid bits; payload registers are not reset.
`default_nettype none
`include "rotation_matrix_about_center_defines.svh"
module rotation_matrix_about_center (
	input wire logic clk,
	input wire logic arst_n,
	rmc_in_if.sink   in_ch,
	rmc_out_if.source out_ch
);
	localparam int N = rmc_pkg::RUN_STEPS;
	logic en;
	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	// stage 1: reduce angle into [-90, 90] with flip
	logic signed [rmc_pkg::AW:0] a0, a1, a2;
	logic signed [rmc_pkg::AW:0] r_c;
	logic flip_c;
	always_comb begin
		a0 = (rmc_pkg::AW+1)'(in_ch.angle_deg);
		// |angle| <= 2^25 < 6*360deg: a few conditional corrections suffice
		a1 = a0;
		if (a1 >= rmc_pkg::DEG_360) a1 = a1 - rmc_pkg::DEG_360;
		if (a1 >= rmc_pkg::DEG_180) a1 = a1 - rmc_pkg::DEG_360;
		if (a1 < -rmc_pkg::DEG_360) a1 = a1 + rmc_pkg::DEG_360;
		if (a1 < -rmc_pkg::DEG_180) a1 = a1 + rmc_pkg::DEG_360;
		a2 = a1;
		flip_c = 1'b0;
		if (a2 > rmc_pkg::DEG_90) begin
			a2 = a2 - rmc_pkg::DEG_180; flip_c = 1'b1;
		end else if (a2 < -rmc_pkg::DEG_90) begin
			a2 = a2 + rmc_pkg::DEG_180; flip_c = 1'b1;
		end
		r_c = a2;
	end
	logic v_s1;
	logic signed [rmc_pkg::AW:0] r_s1;
	logic flip_s1;
	logic signed [rmc_pkg::SW-1:0] scl_s1;
	logic signed [rmc_pkg::CW-1:0] cx_s1, cy_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_ch.valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= r_c; flip_s1 <= flip_c; scl_s1 <= in_ch.scale_factor;
			cx_s1 <= in_ch.center_x; cy_s1 <= in_ch.center_y;
		end
	end

	// stage 2: start vector scale*G rounded to Q30
	logic signed [55:0] sg;
	assign sg = 56'(scl_s1) * 56'(rmc_pkg::GAIN_Q30) + 56'sd32768;
	rmc_pkg::cordic_t c_in;
	logic v_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			c_in.x <= rmc_pkg::XW'(sg >>> 16);
			c_in.y <= '0;
			c_in.z <= rmc_pkg::ZW'({r_s1, 8'd0});
			c_in.flip <= flip_s1;
			c_in.cx <= cx_s1; c_in.cy <= cy_s1;
		end
	end

	// CORDIC chain
	rmc_pkg::cordic_t chain [N+1];
	logic [N:0] vch;
	assign chain[0] = c_in;
	assign vch[0] = v_s2;
	for (genvar g = 0; g < N; g++) begin : g_cell
		rmc_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.step(rmc_pkg::STEP_W'(g)),
			.vld_in(vch[g]), .d_in(chain[g]),
			.vld_out(vch[g+1]), .d_out(chain[g+1])
		);
	end

	// round and saturate alpha, beta
	rmc_pkg::cordic_t cf;
	assign cf = chain[N];
	logic signed [rmc_pkg::XW-1:0] xf, yf, xr, yr;
	logic signed [rmc_pkg::SW-1:0] al_c, be_c;
	localparam logic signed [rmc_pkg::XW-1:0] S_HI = rmc_pkg::XW'(8388607);
	localparam logic signed [rmc_pkg::XW-1:0] S_LO = -rmc_pkg::XW'(8388608);
	always_comb begin
		xf = cf.flip ? -cf.x : cf.x;
		yf = cf.flip ? -cf.y : cf.y;
		xr = (xf + rmc_pkg::XW'(8192)) >>> 14;
		yr = (yf + rmc_pkg::XW'(8192)) >>> 14;
		al_c = (xr > S_HI) ? 24'sh7fffff : (xr < S_LO) ? -24'sh800000 : rmc_pkg::SW'(xr);
		be_c = (yr > S_HI) ? 24'sh7fffff : (yr < S_LO) ? -24'sh800000 : rmc_pkg::SW'(yr);
	end
	logic v_s3;
	logic signed [rmc_pkg::SW-1:0] al_s3, be_s3;
	logic signed [rmc_pkg::CW-1:0] cx_s3, cy_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= vch[N];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			al_s3 <= al_c; be_s3 <= be_c; cx_s3 <= cf.cx; cy_s3 <= cf.cy;
		end
	end

	// stage 4: four products
	logic signed [rmc_pkg::SW:0] oma;
	assign oma = (rmc_pkg::SW+1)'(65536) - (rmc_pkg::SW+1)'(al_s3);
	logic v_s4;
	logic signed [49:0] p_ox_s4, p_by_s4, p_bx_s4, p_oy_s4;
	logic signed [rmc_pkg::SW-1:0] al_s4, be_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			p_ox_s4 <= 50'(oma) * 50'(cx_s3);
			p_by_s4 <= 50'(be_s3) * 50'(cy_s3);
			p_bx_s4 <= 50'(be_s3) * 50'(cx_s3);
			p_oy_s4 <= 50'(oma) * 50'(cy_s3);
			al_s4 <= al_s3; be_s4 <= be_s3;
		end
	end

	// stage 5: sums, rounding, saturation into output register
	logic signed [50:0] tx, ty, txr, tyr;
	localparam logic signed [50:0] T_HI = 51'sd1099511627775;
	localparam logic signed [50:0] T_LO = -51'sd1099511627776;
	logic signed [rmc_pkg::SW-1:0] nb;
	always_comb begin
		tx = 51'(p_ox_s4) - 51'(p_by_s4) + 51'sd32768;
		ty = 51'(p_bx_s4) + 51'(p_oy_s4) + 51'sd32768;
		txr = tx >>> 16;
		tyr = ty >>> 16;
		nb = (be_s4 == -24'sh800000) ? 24'sh7fffff : -be_s4;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_ch.valid <= 1'b0;
		else if (en) out_ch.valid <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.coef_alpha <= al_s4;
			out_ch.coef_beta <= be_s4;
			out_ch.coef_neg_beta <= nb;
			out_ch.shift_x <= (txr > T_HI) ? rmc_pkg::TW'(T_HI) :
				(txr < T_LO) ? rmc_pkg::TW'(T_LO) : rmc_pkg::TW'(txr);
			out_ch.shift_y <= (tyr > T_HI) ? rmc_pkg::TW'(T_HI) :
				(tyr < T_LO) ? rmc_pkg::TW'(T_LO) : rmc_pkg::TW'(tyr);
		end
	end

	`RMC_ASSERT_NEXT(a_hold, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
	`RMC_ASSERT_IMPL(a_rdy, clk, arst_n, !out_ch.valid, in_ch.ready)
	`RMC_ASSERT_NEXT(a_adv, clk, arst_n, in_ch.ready && v_s4, out_ch.valid)
endmodule
`default_nettype wire
